### sv/iirdf2t_pkg.sv
// ----------------------------------------------------------------------------
// IIR direct form II transposed: shared package
// Widths, coefficient layout, transaction types and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf2t_pkg;

   // Filter configuration.
   localparam int ORDER      = 4;
   localparam int COEF_FRAC  = 24;
   localparam int NCOEF      = 2 * ORDER + 1;

   // Field and storage widths.
   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 4;
   localparam int COEF_W     = 32;
   localparam int DLY_W      = 48;

   // Index widths for the coefficient store, the delay chain and the tap count.
   localparam int COEF_IDX_W = $clog2(NCOEF);
   localparam int DLY_IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int TAP_W      = $clog2(ORDER + 1);

   // The 48-bit feedback value is split into a low and a high part so that
   // the shared multiplier stays at 32 by 25 bits.
   localparam int SPLIT_W    = 24;
   localparam int YHI_W      = DLY_W - SPLIT_W;
   localparam int MUL_B_W    = SPLIT_W + 1;
   localparam int PROD_W     = COEF_W + MUL_B_W;
   localparam int ACC_W      = PROD_W + SPLIT_W;
   localparam int SUM_W      = DLY_W + 2;

   typedef enum logic [0:0] {
      CMD_FILTER = 1'b0,
      CMD_LOAD   = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      OPND_X   = 2'd0,
      OPND_YLO = 2'd1,
      OPND_YHI = 2'd2
   } opnd_type;

   typedef struct packed {
      command_type               command;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [IDX_W-1:0]          coef_index;
      logic signed [COEF_W-1:0]  coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } rsp_type;

   typedef struct packed {
      logic                  coef_load;
      logic                  take_x;
      opnd_type              mul_opnd;
      logic [COEF_IDX_W-1:0] mul_idx;
      logic                  y_sum;
      logic                  lo_capture;
      logic                  fb_capture;
      logic                  dly_write;
      logic [TAP_W-1:0]      dly_tap;
      logic                  out_load;
   } ctrl_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

### sv/iirdf2t_ctrl.sv
// ----------------------------------------------------------------------------
// IIR direct form II transposed: controller
// Sequences the shared multiplier over the taps and issues the datapath
// commands for one filter transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf2t_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  iirdf2t_pkg::command_type req_command,
   input  iirdf2t_pkg::status_type  status,
   output logic                     req_stall,
   output iirdf2t_pkg::ctrl_type    ctrl
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_YMUL = 8'b0000_0010,
      ST_YSUM = 8'b0000_0100,
      ST_TLO  = 8'b0000_1000,
      ST_THI  = 8'b0001_0000,
      ST_TBX  = 8'b0010_0000,
      ST_LAST = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type                        state_ff, state_in;
   logic [iirdf2t_pkg::TAP_W-1:0]     tap_ff, tap_in;
   logic [iirdf2t_pkg::COEF_IDX_W-1:0] b_idx, a_idx;
   logic                             accept;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign b_idx = iirdf2t_pkg::COEF_IDX_W'(tap_ff);
   assign a_idx = iirdf2t_pkg::COEF_IDX_W'(iirdf2t_pkg::ORDER) + b_idx;

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      ctrl     = '0;
      ctrl.mul_opnd = iirdf2t_pkg::OPND_X;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == iirdf2t_pkg::CMD_LOAD) begin
                  ctrl.coef_load = 1'b1;
               end else begin
                  ctrl.take_x = 1'b1;
                  state_in    = ST_YMUL;
               end
            end
         end
         ST_YMUL: begin
            ctrl.mul_idx = '0;
            state_in     = ST_YSUM;
         end
         ST_YSUM: begin
            ctrl.y_sum = 1'b1;
            tap_in     = iirdf2t_pkg::TAP_W'(1);
            state_in   = ST_TLO;
         end
         ST_TLO: begin
            ctrl.mul_opnd = iirdf2t_pkg::OPND_YLO;
            ctrl.mul_idx  = a_idx;
            // The previous tap's delay entry is completed here.
            ctrl.dly_write = (tap_ff != iirdf2t_pkg::TAP_W'(1));
            ctrl.dly_tap   = tap_ff - iirdf2t_pkg::TAP_W'(1);
            state_in       = ST_THI;
         end
         ST_THI: begin
            ctrl.mul_opnd   = iirdf2t_pkg::OPND_YHI;
            ctrl.mul_idx    = a_idx;
            ctrl.lo_capture = 1'b1;
            state_in        = ST_TBX;
         end
         ST_TBX: begin
            ctrl.mul_idx    = b_idx;
            ctrl.fb_capture = 1'b1;
            if (tap_ff == iirdf2t_pkg::TAP_W'(iirdf2t_pkg::ORDER)) begin
               state_in = ST_LAST;
            end else begin
               tap_in   = tap_ff + iirdf2t_pkg::TAP_W'(1);
               state_in = ST_TLO;
            end
         end
         ST_LAST: begin
            ctrl.dly_write = 1'b1;
            ctrl.dly_tap   = tap_ff;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (!status.rsp_busy) begin
               ctrl.out_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

`default_nettype wire

### sv/iirdf2t_dp.sv
// ----------------------------------------------------------------------------
// IIR direct form II transposed: datapath
// Coefficient store, delay chain, shared 32 by 25 multiplier, rounding and
// saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf2t_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  iirdf2t_pkg::req_type    req_payload,
   input  iirdf2t_pkg::ctrl_type   ctrl,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output iirdf2t_pkg::rsp_type    rsp_payload,
   output iirdf2t_pkg::status_type status
);

   localparam int F      = iirdf2t_pkg::COEF_FRAC;
   localparam int SUM_W  = iirdf2t_pkg::SUM_W;
   localparam int ACC_W  = iirdf2t_pkg::ACC_W;
   localparam int DLY_W  = iirdf2t_pkg::DLY_W;
   localparam int SMP_W  = iirdf2t_pkg::SAMPLE_W;
   localparam int PROD_W = iirdf2t_pkg::PROD_W;
   localparam int SPL_W  = iirdf2t_pkg::SPLIT_W;
   localparam int MB_W   = iirdf2t_pkg::MUL_B_W;

   logic signed [iirdf2t_pkg::COEF_W-1:0] coef_ff [iirdf2t_pkg::NCOEF];
   logic signed [DLY_W-1:0]               dly_ff  [iirdf2t_pkg::ORDER];

   logic signed [SMP_W-1:0]  x_ff;
   logic signed [DLY_W-1:0]  yfb_ff;
   logic signed [PROD_W-1:0] mul_ff, lo_ff;
   logic signed [DLY_W-1:0]  fb_ff;
   logic signed [SMP_W-1:0]  y_out_ff;
   logic                     y_clip_ff;
   logic                     rsp_valid_ff;
   iirdf2t_pkg::rsp_type     rsp_ff;

   logic signed [iirdf2t_pkg::COEF_W-1:0] mul_a;
   logic signed [MB_W-1:0]                mul_b;
   logic signed [SUM_W-1:0] yfull, y_rnd, t_sum, d_ext;
   logic signed [DLY_W-1:0] yfb_in, fb_in, t_sat, d_sel;
   logic signed [SMP_W-1:0] y_out_in;
   logic                    y_clip_in;
   logic signed [ACC_W-1:0] acc;

   // Shared multiplier, one product per cycle.
   always_comb begin
      mul_a = coef_ff[ctrl.mul_idx];
      case (ctrl.mul_opnd)
         iirdf2t_pkg::OPND_X:
            mul_b = {{(MB_W-SMP_W){x_ff[SMP_W-1]}}, x_ff};
         iirdf2t_pkg::OPND_YLO:
            mul_b = {1'b0, yfb_ff[SPL_W-1:0]};
         iirdf2t_pkg::OPND_YHI:
            mul_b = {{(MB_W-iirdf2t_pkg::YHI_W){yfb_ff[DLY_W-1]}},
                     yfb_ff[DLY_W-1:SPL_W]};
         default:
            mul_b = '0;
      endcase
   end

   // Output sum: the b0*x product always fits the delay format.
   always_comb begin
      yfull = $signed(mul_ff[SUM_W-1:0])
            + $signed({{(SUM_W-DLY_W){dly_ff[0][DLY_W-1]}}, dly_ff[0]});
      if ((&yfull[SUM_W-1:DLY_W-1]) || !(|yfull[SUM_W-1:DLY_W-1])) begin
         yfb_in = yfull[DLY_W-1:0];
      end else begin
         yfb_in = {yfull[SUM_W-1], {(DLY_W-1){~yfull[SUM_W-1]}}};
      end
      y_rnd = yfull + (SUM_W'(1) <<< (F - 1));
      if ((&y_rnd[SUM_W-1:F+SMP_W-1]) || !(|y_rnd[SUM_W-1:F+SMP_W-1])) begin
         y_out_in  = y_rnd[F+SMP_W-1:F];
         y_clip_in = 1'b0;
      end else begin
         y_out_in  = {y_rnd[SUM_W-1], {(SMP_W-1){~y_rnd[SUM_W-1]}}};
         y_clip_in = 1'b1;
      end
   end

   // Feedback product a*y, rebuilt from its two partial products and rounded.
   always_comb begin
      acc = $signed({mul_ff, {SPL_W{1'b0}}})
          + $signed({{SPL_W{lo_ff[PROD_W-1]}}, lo_ff})
          + (ACC_W'(1) <<< (F - 1));
      if ((&acc[ACC_W-1:F+DLY_W-1]) || !(|acc[ACC_W-1:F+DLY_W-1])) begin
         fb_in = acc[F+DLY_W-1:F];
      end else begin
         fb_in = {acc[ACC_W-1], {(DLY_W-1){~acc[ACC_W-1]}}};
      end
   end

   // Delay update: the last entry has no successor to add.
   always_comb begin
      if (ctrl.dly_tap == iirdf2t_pkg::TAP_W'(iirdf2t_pkg::ORDER)) begin
         d_sel = '0;
      end else begin
         d_sel = dly_ff[iirdf2t_pkg::DLY_IDX_W'(ctrl.dly_tap)];
      end
      d_ext = {{(SUM_W-DLY_W){d_sel[DLY_W-1]}}, d_sel};
      t_sum = d_ext + $signed(mul_ff[SUM_W-1:0])
            - $signed({{(SUM_W-DLY_W){fb_ff[DLY_W-1]}}, fb_ff});
      if ((&t_sum[SUM_W-1:DLY_W-1]) || !(|t_sum[SUM_W-1:DLY_W-1])) begin
         t_sat = t_sum[DLY_W-1:0];
      end else begin
         t_sat = {t_sum[SUM_W-1], {(DLY_W-1){~t_sum[SUM_W-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iirdf2t_pkg::NCOEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (ctrl.coef_load &&
                   (int'(req_payload.coef_index) < iirdf2t_pkg::NCOEF)) begin
         coef_ff[iirdf2t_pkg::COEF_IDX_W'(req_payload.coef_index)] <=
            req_payload.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iirdf2t_pkg::ORDER; i++) begin
            dly_ff[i] <= '0;
         end
      end else if (ctrl.dly_write) begin
         dly_ff[iirdf2t_pkg::DLY_IDX_W'(ctrl.dly_tap - iirdf2t_pkg::TAP_W'(1))] <= t_sat;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (ctrl.take_x) begin
         x_ff <= req_payload.sample_in;
      end
      if (ctrl.y_sum) begin
         yfb_ff    <= yfb_in;
         y_out_ff  <= y_out_in;
         y_clip_ff <= y_clip_in;
      end
      if (ctrl.lo_capture) begin
         lo_ff <= mul_ff;
      end
      if (ctrl.fb_capture) begin
         fb_ff <= fb_in;
      end
      if (ctrl.out_load) begin
         rsp_ff.sample_out <= y_out_ff;
         rsp_ff.clipped    <= y_clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

endmodule

`default_nettype wire

### sv/iir_direct_form_two_transposed_unit.sv
// ----------------------------------------------------------------------------
// IIR direct form II transposed filter unit
// Fixed-point IIR filter of order ORDER on signed 16-bit audio samples, with
// Q7.24 coefficients, a 48-bit delay chain and a saturated, rounded output.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Transaction
//   req_*     in         req_valid/req_stall   filter one sample or load a coefficient
//   rsp_*     out        rsp_valid/rsp_stall   filtered sample and clip flag
//
// A coefficient load leaves the controller idle, so the unit is ready for the next
// transaction straight away; it produces no result.
// A filter transaction runs the single shared 32 by 25 multiplier for b0*x and
// then for three products per tap, the feedback halves and the forward
// coefficient, before its result is registered.
// Reset is synchronous and clears the coefficient store and the delay chain.
// The result register frees the unit from the consumer: only when a previous
// result is still stalled at the end of a filter transaction does the unit wait.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_two_transposed_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  iirdf2t_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output iirdf2t_pkg::rsp_type rsp_payload
);

   // Commands from the controller and status back from the datapath.
   iirdf2t_pkg::ctrl_type   ctrl;
   iirdf2t_pkg::status_type status;

   // The controller owns the sequence: it accepts transactions only when idle
   // and steps the shared multiplier through b0, then each tap's feedback
   // halves and forward coefficient.
   iirdf2t_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .status      (status),
      .req_stall   (req_stall),
      .ctrl        (ctrl)
   );

   // The datapath holds all stored values and the arithmetic, and drives the
   // result channel from its own output register.
   iirdf2t_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctrl        (ctrl),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

endmodule

`default_nettype wire
